// ===== rtl/core/aeske_pkg.sv =====
// Shared constants and functions for the AES-128 key expansion: S-box, xtime, widths.
package aeske_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned KEY_W   = 128;
  localparam int unsigned ROUND_W = 4;
  localparam logic [7:0]  RCON_FIRST = 8'h01;
  localparam logic [7:0]  GF_POLY    = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Double in GF(2^8), modulus x^8 + x^4 + x^3 + x + 1.
  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  // Substitute each byte of a word through the S-box.
  function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// ===== rtl/core/aeske_round.sv =====
// One AES-128 key schedule round: RotWord, SubWord, round constant and word chain.
module aeske_round (
  input  logic [aeske_pkg::KEY_W-1:0] key_i,
  input  logic [7:0]                  rcon_i,
  output logic [aeske_pkg::KEY_W-1:0] key_o
);
  import aeske_pkg::*;

  logic [WORD_W-1:0] w0, w1, w2, w3;
  logic [WORD_W-1:0] t;
  logic [WORD_W-1:0] n0, n1, n2, n3;

  assign {w0, w1, w2, w3} = key_i;

  // rotate left by one byte, substitute, fold in the round constant
  assign t  = sub_word({w3[23:0], w3[31:24]}) ^ {rcon_i, 24'h000000};
  assign n0 = w0 ^ t;
  assign n1 = w1 ^ n0;
  assign n2 = w2 ^ n1;
  assign n3 = w3 ^ n2;

  assign key_o = {n0, n1, n2, n3};

endmodule

// ===== rtl/core/aes128_key_expansion.sv =====
// Top level of the AES-128 key expansion: request capture, round sequencer, result registers.
// Round key 0 is shown the cycle after the request is taken, then one key per cycle.
// One request at a time: the single round unit is reused once per cycle on the previous
//   round key.
// busy falls with the last round key, so a new request may be taken while it is shown.
// Reset (rst_n low, synchronous) clears busy and the result strobe; key data is not reset.
module aes128_key_expansion #(
  parameter int unsigned NUM_ROUNDS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [aeske_pkg::HALF_W-1:0]  in_key_high,
  input  logic [aeske_pkg::HALF_W-1:0]  in_key_low,
  output logic                          out_valid,
  output logic [aeske_pkg::HALF_W-1:0]  out_round_key_high,
  output logic [aeske_pkg::HALF_W-1:0]  out_round_key_low,
  output logic [aeske_pkg::ROUND_W-1:0] out_round_number,
  output logic                          out_last_round
);
  import aeske_pkg::*;

  localparam logic [ROUND_W-1:0] LAST_RND = ROUND_W'(NUM_ROUNDS);

  // The result register doubles as the working key: each round is built from the one shown.
  logic [KEY_W-1:0]   key_r,   key_nxt;
  logic [7:0]         rcon_r,  rcon_nxt;
  logic [ROUND_W-1:0] rnd_r,   rnd_nxt;
  logic               busy_r,  busy_nxt;
  logic               valid_r, valid_nxt;
  logic               last_r,  last_nxt;
  logic [KEY_W-1:0]   round_key;
  logic               accept;

  aeske_round u_round (
    .key_i  (key_r),
    .rcon_i (rcon_r),
    .key_o  (round_key)
  );

  assign accept = start && !busy_r;

  always_comb begin
    key_nxt   = key_r;
    rcon_nxt  = rcon_r;
    rnd_nxt   = rnd_r;
    busy_nxt  = busy_r;
    valid_nxt = 1'b0;
    last_nxt  = last_r;
    if (busy_r) begin
      // advance one round: take the round unit's result, step the constant
      key_nxt   = round_key;
      rcon_nxt  = xtime(rcon_r);
      rnd_nxt   = rnd_r + 1'b1;
      valid_nxt = 1'b1;
      last_nxt  = (rnd_nxt == LAST_RND);
      busy_nxt  = !last_nxt;
    end else if (accept) begin
      // show the cipher key itself as round 0 and arm the sequencer
      key_nxt   = {in_key_high, in_key_low};
      rcon_nxt  = RCON_FIRST;
      rnd_nxt   = '0;
      valid_nxt = 1'b1;
      last_nxt  = 1'b0;
      busy_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
    key_r  <= key_nxt;
    rcon_r <= rcon_nxt;
    rnd_r  <= rnd_nxt;
    last_r <= last_nxt;
  end

  assign busy               = busy_r;
  assign out_valid          = valid_r;
  assign out_round_key_high = key_r[KEY_W-1:HALF_W];
  assign out_round_key_low  = key_r[HALF_W-1:0];
  assign out_round_number   = rnd_r;
  assign out_last_round     = last_r;

endmodule
